### hdl/nv12sc_pkg.sv
package nv12sc_pkg;

  // field widths
  localparam int unsigned ORIGIN_W  = 12;
  localparam int unsigned STEP_W    = 20;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned PITCH_W   = 14;
  localparam int unsigned SRC_OFF_W = 27;
  localparam int unsigned DST_OFF_W = 25;
  localparam int unsigned ACC_W     = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = STEP_W;

  // register reset values
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(20'h10000);
  localparam logic [DIM_W-1:0]  DIM_RST  = DIM_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_ORIGIN_X = 3'd0,
    REG_SRC_ORIGIN_Y = 3'd1,
    REG_X_STEP       = 3'd2,
    REG_Y_STEP       = 3'd3,
    REG_OUT_WIDTH    = 3'd4,
    REG_OUT_HEIGHT   = 3'd5,
    REG_SRC_PITCH    = 3'd6,
    REG_DST_PITCH    = 3'd7
  } cfg_reg_e;

endpackage

### hdl/nv12_nearest_scale_address_gen.sv
// nv12 nearest-neighbor scaler address generator
//
// channels: the request channel (in_valid_i / in_ready_o, restart_i) asks
// for one destination pixel; restart_i = 1 jumps back to pixel (0,0). the
// result channel (out_valid_o / out_ready_i) gives the source luma and uv
// pair offsets, the destination luma and uv offsets, chroma_valid_o on even
// columns, row_end_o and frame_end_o. the config channel (cfg_valid_i /
// cfg_ready_o, cfg_index_i, cfg_data_i) writes the eight setup registers and
// is always ready; write it only while no request is in flight.
// pipeline: stage a forms the source coordinate, stage b does the pitch
// multiplies. throughput: one request per cycle unless out_ready_i stalls,
// set by the two-register pipeline; the walk counters and accumulators
// advance in the cycle a request is taken.
// reset: registers return to origin 0, unit steps, 1x1 region, zero
// pitches, and the walk restarts at pixel (0,0). pipeline valids clear.
// stall: while out_ready_i is low the result holds; stage a still fills,
// so one more request is taken before in_ready_o drops.
module nv12_nearest_scale_address_gen
  import nv12sc_pkg::*;
#(
  parameter int unsigned MAX_DIM   = 4096,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SRC_OFF_W-1:0]  src_luma_offset_o,
  output logic [SRC_OFF_W-1:0]  src_chroma_offset_o,
  output logic [DST_OFF_W-1:0]  dst_luma_offset_o,
  output logic [DST_OFF_W-1:0]  dst_chroma_offset_o,
  output logic                  chroma_valid_o,
  output logic                  row_end_o,
  output logic                  frame_end_o
);

  // counter holds up to MAX_DIM-1
  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  // compare width covers count+1 and the size register
  localparam int unsigned CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
  // source coordinate: origin plus integer part of the accumulator
  localparam int unsigned INT_W = ACC_W - FRAC_BITS;
  localparam int unsigned SX_W  = ((INT_W > ORIGIN_W) ? INT_W : ORIGIN_W) + 1;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [ORIGIN_W-1:0] src_origin_x_q, src_origin_y_q;
  logic [STEP_W-1:0]   x_step_q, y_step_q;
  logic [DIM_W-1:0]    out_width_q, out_height_q;
  logic [PITCH_W-1:0]  src_pitch_q, dst_pitch_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_origin_x_q <= '0;
      src_origin_y_q <= '0;
      x_step_q       <= STEP_RST;
      y_step_q       <= STEP_RST;
      out_width_q    <= DIM_RST;
      out_height_q   <= DIM_RST;
      src_pitch_q    <= '0;
      dst_pitch_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SRC_ORIGIN_X: src_origin_x_q <= cfg_data_i[ORIGIN_W-1:0];
        REG_SRC_ORIGIN_Y: src_origin_y_q <= cfg_data_i[ORIGIN_W-1:0];
        REG_X_STEP:       x_step_q       <= cfg_data_i[STEP_W-1:0];
        REG_Y_STEP:       y_step_q       <= cfg_data_i[STEP_W-1:0];
        REG_OUT_WIDTH:    out_width_q    <= cfg_data_i[DIM_W-1:0];
        REG_OUT_HEIGHT:   out_height_q   <= cfg_data_i[DIM_W-1:0];
        REG_SRC_PITCH:    src_pitch_q    <= cfg_data_i[PITCH_W-1:0];
        REG_DST_PITCH:    dst_pitch_q    <= cfg_data_i[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective size: zero acts as one, oversize clamps to MAX_DIM
  logic [CMP_W-1:0] width_eff, height_eff;

  always_comb begin
    if (out_width_q == '0) begin
      width_eff = CMP_W'(1);
    end else if (CMP_W'(out_width_q) > CMP_W'(MAX_DIM)) begin
      width_eff = CMP_W'(MAX_DIM);
    end else begin
      width_eff = CMP_W'(out_width_q);
    end
    if (out_height_q == '0) begin
      height_eff = CMP_W'(1);
    end else if (CMP_W'(out_height_q) > CMP_W'(MAX_DIM)) begin
      height_eff = CMP_W'(MAX_DIM);
    end else begin
      height_eff = CMP_W'(out_height_q);
    end
  end

  // ---------------------------------------------------------------------
  // pipeline handshake
  // ---------------------------------------------------------------------
  logic a_valid_q, b_valid_q;
  logic adv_a, adv_b, in_acc;

  assign adv_b      = !b_valid_q || out_ready_i;
  assign adv_a      = !a_valid_q || adv_b;
  assign in_ready_o = adv_a;
  assign in_acc     = in_valid_i && adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_q <= in_valid_i;
      end
      if (adv_b) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // raster walk state
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] col_q, row_q, col_cur, row_cur;
  logic [ACC_W-1:0] x_acc_q, y_acc_q, x_acc_cur, y_acc_cur;
  logic             row_last, frame_last;
  logic [SX_W-1:0]  sx_d, sy_d;

  // restart takes effect before the pixel is formed
  assign col_cur   = restart_i ? '0 : col_q;
  assign row_cur   = restart_i ? '0 : row_q;
  assign x_acc_cur = restart_i ? '0 : x_acc_q;
  assign y_acc_cur = restart_i ? '0 : y_acc_q;

  // a size shrunk mid-frame ends the row or frame at the current pixel
  assign row_last   = (CMP_W'(col_cur) + CMP_W'(1)) >= width_eff;
  assign frame_last = row_last && ((CMP_W'(row_cur) + CMP_W'(1)) >= height_eff);

  assign sx_d = SX_W'(src_origin_x_q) + SX_W'(x_acc_cur >> FRAC_BITS);
  assign sy_d = SX_W'(src_origin_y_q) + SX_W'(y_acc_cur >> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      x_acc_q <= '0;
      y_acc_q <= '0;
    end else if (in_acc) begin
      if (frame_last) begin
        col_q   <= '0;
        row_q   <= '0;
        x_acc_q <= '0;
        y_acc_q <= '0;
      end else if (row_last) begin
        col_q   <= '0;
        x_acc_q <= '0;
        row_q   <= row_cur + CNT_W'(1);
        y_acc_q <= y_acc_cur + ACC_W'(y_step_q);
      end else begin
        col_q   <= col_cur + CNT_W'(1);
        row_q   <= row_cur;
        x_acc_q <= x_acc_cur + ACC_W'(x_step_q);
        y_acc_q <= y_acc_cur;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage a: source coordinate and position
  // ---------------------------------------------------------------------
  logic [SX_W-1:0]  sx_a_q, sy_a_q;
  logic [CNT_W-1:0] col_a_q, row_a_q;
  logic             row_end_a_q, frame_end_a_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sx_a_q        <= sx_d;
      sy_a_q        <= sy_d;
      col_a_q       <= col_cur;
      row_a_q       <= row_cur;
      row_end_a_q   <= row_last;
      frame_end_a_q <= frame_last;
    end
  end

  // ---------------------------------------------------------------------
  // stage b: pitch multiplies, offsets wrap at field width
  // ---------------------------------------------------------------------
  logic                 even_a;
  logic [SRC_OFF_W-1:0] src_luma_d, src_chroma_d;
  logic [DST_OFF_W-1:0] dst_luma_d, dst_chroma_d;
  logic [SX_W-1:0]      sx_pair;

  assign even_a  = !col_a_q[0];
  // uv pairs are two bytes wide, so the pair column is sx with bit 0 cleared
  assign sx_pair = {sx_a_q[SX_W-1:1], 1'b0};

  assign src_luma_d = SRC_OFF_W'(sy_a_q) * SRC_OFF_W'(src_pitch_q)
                    + SRC_OFF_W'(sx_a_q);
  assign src_chroma_d = even_a
    ? SRC_OFF_W'(sy_a_q >> 1) * SRC_OFF_W'(src_pitch_q) + SRC_OFF_W'(sx_pair)
    : '0;
  assign dst_luma_d = DST_OFF_W'(row_a_q) * DST_OFF_W'(dst_pitch_q)
                    + DST_OFF_W'(col_a_q);
  assign dst_chroma_d = even_a
    ? DST_OFF_W'(row_a_q >> 1) * DST_OFF_W'(dst_pitch_q) + DST_OFF_W'(col_a_q)
    : '0;

  logic [SRC_OFF_W-1:0] src_luma_q, src_chroma_q;
  logic [DST_OFF_W-1:0] dst_luma_q, dst_chroma_q;
  logic                 chroma_valid_q, row_end_q, frame_end_q;

  always_ff @(posedge clk_i) begin
    if (adv_b && a_valid_q) begin
      src_luma_q     <= src_luma_d;
      src_chroma_q   <= src_chroma_d;
      dst_luma_q     <= dst_luma_d;
      dst_chroma_q   <= dst_chroma_d;
      chroma_valid_q <= even_a;
      row_end_q      <= row_end_a_q;
      frame_end_q    <= frame_end_a_q;
    end
  end

  assign out_valid_o         = b_valid_q;
  assign src_luma_offset_o   = src_luma_q;
  assign src_chroma_offset_o = src_chroma_q;
  assign dst_luma_offset_o   = dst_luma_q;
  assign dst_chroma_offset_o = dst_chroma_q;
  assign chroma_valid_o      = chroma_valid_q;
  assign row_end_o           = row_end_q;
  assign frame_end_o         = frame_end_q;

endmodule

### hdl/nv12sc_checker.sv
module nv12sc_checker
  import nv12sc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [SRC_OFF_W-1:0]  src_luma_offset_o,
  input logic [SRC_OFF_W-1:0]  src_chroma_offset_o,
  input logic [DST_OFF_W-1:0]  dst_luma_offset_o,
  input logic [DST_OFF_W-1:0]  dst_chroma_offset_o,
  input logic                  chroma_valid_o,
  input logic                  row_end_o,
  input logic                  frame_end_o
);

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(src_luma_offset_o) && $stable(dst_luma_offset_o)
      && $stable(row_end_o) && $stable(frame_end_o))
    else $error("result changed while stalled");

  // odd columns carry no uv pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chroma_valid_o |->
      src_chroma_offset_o == '0 && dst_chroma_offset_o == '0)
    else $error("uv offset on odd column");

  // last pixel of the region is also last of its row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame end without row end");

  // an empty result register never blocks requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request blocked with empty output");

endmodule

bind nv12_nearest_scale_address_gen nv12sc_checker u_nv12sc_checker (.*);

### dv/testbench.sv
module testbench;
  import nv12sc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM       = 4096;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int unsigned DRAIN_LIMIT   = 4000;  // cycles to wait for pending results
  localparam int unsigned SETTLE_CYCLES = 4;     // two-stage pipe plus margin
  localparam int unsigned MAX_REPORTS   = 100;

  // one expected result, field for field
  typedef struct packed {
    logic [SRC_OFF_W-1:0] src_luma;
    logic [SRC_OFF_W-1:0] src_chroma;
    logic [DST_OFF_W-1:0] dst_luma;
    logic [DST_OFF_W-1:0] dst_chroma;
    logic                 chroma_valid;
    logic                 row_end;
    logic                 frame_end;
  } pix_addr_t;

  // clock, reset and block inputs, all known from time zero
  logic                  clk_i      = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  cfg_reg_e              cfg_index  = REG_SRC_ORIGIN_X;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  restart_in = 1'b0;
  logic                  out_ready  = 1'b0;

  logic                  cfg_ready_o;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [SRC_OFF_W-1:0]  src_luma_offset_o;
  logic [SRC_OFF_W-1:0]  src_chroma_offset_o;
  logic [DST_OFF_W-1:0]  dst_luma_offset_o;
  logic [DST_OFF_W-1:0]  dst_chroma_offset_o;
  logic                  chroma_valid_o;
  logic                  row_end_o;
  logic                  frame_end_o;

  // random idling on both sides; off for the closing stretch
  bit idle_en = 1'b1;
  // asks the result sink for one long hold-off
  bit sink_hold = 1'b0;

  int unsigned n_errors = 0;

  // expected pixel addresses, oldest first
  pix_addr_t pixel_q[$];

  // mirror of the setup registers
  logic [ORIGIN_W-1:0] cfg_ox;
  logic [ORIGIN_W-1:0] cfg_oy;
  logic [STEP_W-1:0]   cfg_xstep;
  logic [STEP_W-1:0]   cfg_ystep;
  logic [DIM_W-1:0]    cfg_w;
  logic [DIM_W-1:0]    cfg_h;
  logic [PITCH_W-1:0]  cfg_spitch;
  logic [PITCH_W-1:0]  cfg_dpitch;

  // raster walk position of the next pixel and the source accumulators
  logic [11:0]         walk_col;
  logic [11:0]         walk_row;
  logic [ACC_W-1:0]    walk_xacc;
  logic [ACC_W-1:0]    walk_yacc;

  nv12_nearest_scale_address_gen #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .restart_i          (restart_in),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .src_luma_offset_o  (src_luma_offset_o),
    .src_chroma_offset_o(src_chroma_offset_o),
    .dst_luma_offset_o  (dst_luma_offset_o),
    .dst_chroma_offset_o(dst_chroma_offset_o),
    .chroma_valid_o     (chroma_valid_o),
    .row_end_o          (row_end_o),
    .frame_end_o        (frame_end_o)
  );

  initial begin : clock_gen
    forever #4 clk_i = ~clk_i;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // size register as the walk sees it: zero acts as one, clamp at the maximum
  function automatic longint unsigned eff_size(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // addresses of the pixel a request produces; advances the walk
  function automatic pix_addr_t predict_pixel(input logic restart);
    pix_addr_t       p;
    longint unsigned w, h, sx, sy, col, row;
    logic            even, rend, fend;
    w = eff_size(cfg_w);
    h = eff_size(cfg_h);
    if (restart) begin
      walk_col  = '0;
      walk_row  = '0;
      walk_xacc = '0;
      walk_yacc = '0;
    end
    col  = walk_col;
    row  = walk_row;
    // source coordinate is the integer part of the 16.16 accumulator
    sx   = longint'(cfg_ox) + (longint'(walk_xacc) >> FRAC_BITS);
    sy   = longint'(cfg_oy) + (longint'(walk_yacc) >> FRAC_BITS);
    even = (walk_col[0] == 1'b0);
    rend = (col + 1 >= w);
    // a size shrunk below the position also ends the row or the frame here
    fend = rend && (row + 1 >= h);

    p.src_luma     = SRC_OFF_W'(sy * cfg_spitch + sx);
    p.src_chroma   = even ? SRC_OFF_W'((sy >> 1) * cfg_spitch + (sx >> 1) * 2) : '0;
    p.dst_luma     = DST_OFF_W'(row * cfg_dpitch + col);
    p.dst_chroma   = even ? DST_OFF_W'((row >> 1) * cfg_dpitch + col) : '0;
    p.chroma_valid = even;
    p.row_end      = rend;
    p.frame_end    = fend;

    if (fend) begin
      walk_col  = '0;
      walk_row  = '0;
      walk_xacc = '0;
      walk_yacc = '0;
    end else if (rend) begin
      walk_col  = '0;
      walk_xacc = '0;
      walk_row  = walk_row + 1'b1;
      walk_yacc = walk_yacc + cfg_ystep;  // wraps at 32 bits
    end else begin
      walk_col  = walk_col + 1'b1;
      walk_xacc = walk_xacc + cfg_xstep;
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (n_errors < MAX_REPORTS)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    pix_addr_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("result with no request pending", src_luma_offset_o, 0);
      end else begin
        want = pixel_q.pop_front();
        if (src_luma_offset_o !== want.src_luma)
          report_mismatch("src_luma_offset", src_luma_offset_o, want.src_luma);
        if (src_chroma_offset_o !== want.src_chroma)
          report_mismatch("src_chroma_offset", src_chroma_offset_o, want.src_chroma);
        if (dst_luma_offset_o !== want.dst_luma)
          report_mismatch("dst_luma_offset", dst_luma_offset_o, want.dst_luma);
        if (dst_chroma_offset_o !== want.dst_chroma)
          report_mismatch("dst_chroma_offset", dst_chroma_offset_o, want.dst_chroma);
        if (chroma_valid_o !== want.chroma_valid)
          report_mismatch("chroma_valid", chroma_valid_o, want.chroma_valid);
        if (row_end_o !== want.row_end)
          report_mismatch("row_end", row_end_o, want.row_end);
        if (frame_end_o !== want.frame_end)
          report_mismatch("frame_end", frame_end_o, want.frame_end);
      end
    end
  end

  // result sink: random stall bursts, or one long hold-off on demand
  initial begin : result_sink
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one setup write, only while nothing is in flight
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SRC_ORIGIN_X: cfg_ox     = data[ORIGIN_W-1:0];
      REG_SRC_ORIGIN_Y: cfg_oy     = data[ORIGIN_W-1:0];
      REG_X_STEP:       cfg_xstep  = data[STEP_W-1:0];
      REG_Y_STEP:       cfg_ystep  = data[STEP_W-1:0];
      REG_OUT_WIDTH:    cfg_w      = data[DIM_W-1:0];
      REG_OUT_HEIGHT:   cfg_h      = data[DIM_W-1:0];
      REG_SRC_PITCH:    cfg_spitch = data[PITCH_W-1:0];
      REG_DST_PITCH:    cfg_dpitch = data[PITCH_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one request and wait until it is taken; valid stays high afterwards
  // so a back-to-back request keeps the line up without a dip
  task automatic send_request(input logic restart);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    restart_in <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    pixel_q.push_back(predict_pixel(restart));
  endtask

  // stop offering and wait for every pending result, then let the pipe settle
  task automatic wait_drained();
    int unsigned spins;
    in_valid <= 1'b0;
    spins = 0;
    while (pixel_q.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spins++;
    end
    if (pixel_q.size() != 0) begin
      report_mismatch("results never arrived", pixel_q.size(), 0);
      pixel_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_walk(input int unsigned n, input int unsigned restart_pct);
    repeat (n) send_request($urandom_range(0, 99) < restart_pct);
  endtask

  // ---------------------------------------------------------------------------
  // random setup values, biased toward the edges
  // ---------------------------------------------------------------------------

  function automatic logic [CFG_DATA_W-1:0] pick_origin();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CFG_DATA_W'(4095);
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0, 1:    return STEP_RST;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return CFG_DATA_W'($urandom_range(1, 'h30000));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // mostly tiny regions so frames wrap often; now and then zero or oversize
  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(MAX_DIM);
      2, 3:    return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pitch();
    case ($urandom_range(0, 4))
      0:       return CFG_DATA_W'(8192);
      1:       return '0;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic randomize_setup();
    write_reg(REG_SRC_ORIGIN_X, pick_origin());
    write_reg(REG_SRC_ORIGIN_Y, pick_origin());
    write_reg(REG_X_STEP,       pick_step());
    write_reg(REG_Y_STEP,       pick_step());
    write_reg(REG_OUT_WIDTH,    pick_size());
    write_reg(REG_OUT_HEIGHT,   pick_size());
    write_reg(REG_SRC_PITCH,    pick_pitch());
    write_reg(REG_DST_PITCH,    pick_pitch());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset setup: 1x1 region, every request is a frame end
  task automatic test_reset_values();
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_drained();
  endtask

  // far corner origin, full steps, pitch data above the register width,
  // odd columns, wrap after the frame end and a restart mid-frame
  task automatic test_walk_extremes();
    write_reg(REG_SRC_ORIGIN_X, '1);
    write_reg(REG_SRC_ORIGIN_Y, '1);
    write_reg(REG_X_STEP,       '1);
    write_reg(REG_Y_STEP,       '1);
    write_reg(REG_OUT_WIDTH,    CFG_DATA_W'(3));
    write_reg(REG_OUT_HEIGHT,   CFG_DATA_W'(2));
    write_reg(REG_SRC_PITCH,    '1);
    write_reg(REG_DST_PITCH,    '1);
    send_request(1'b1);
    send_walk(7, 0);
    send_request(1'b1);
    send_walk(2, 0);
    wait_drained();
  endtask

  // zero steps and zero sizes, then width 2, then oversize width and height
  task automatic test_size_limits();
    write_reg(REG_SRC_ORIGIN_X, CFG_DATA_W'(17));
    write_reg(REG_SRC_ORIGIN_Y, CFG_DATA_W'(5));
    write_reg(REG_X_STEP,       '0);
    write_reg(REG_Y_STEP,       '0);
    write_reg(REG_OUT_WIDTH,    '0);
    write_reg(REG_OUT_HEIGHT,   '0);
    write_reg(REG_SRC_PITCH,    CFG_DATA_W'(8192));
    write_reg(REG_DST_PITCH,    CFG_DATA_W'(8192));
    send_walk(3, 0);
    wait_drained();
    write_reg(REG_OUT_WIDTH,    CFG_DATA_W'(2));
    send_walk(4, 0);
    wait_drained();
    // masked to 8191, clamps to the maximum width
    write_reg(REG_OUT_WIDTH,    '1);
    write_reg(REG_OUT_HEIGHT,   CFG_DATA_W'(MAX_DIM + 1));
    write_reg(REG_X_STEP,       CFG_DATA_W'('h8000));
    send_request(1'b1);
    send_walk(5, 0);
    wait_drained();
  endtask

  // region shrinks under the walk position between requests
  task automatic test_shrunk_size();
    write_reg(REG_SRC_ORIGIN_X, '0);
    write_reg(REG_SRC_ORIGIN_Y, '0);
    write_reg(REG_X_STEP,       CFG_DATA_W'('h18000));
    write_reg(REG_Y_STEP,       CFG_DATA_W'('h28000));
    write_reg(REG_OUT_WIDTH,    CFG_DATA_W'(8));
    write_reg(REG_OUT_HEIGHT,   CFG_DATA_W'(4));
    write_reg(REG_SRC_PITCH,    CFG_DATA_W'(640));
    write_reg(REG_DST_PITCH,    CFG_DATA_W'(320));
    send_request(1'b1);
    send_walk(5, 0);
    wait_drained();
    // column 6 lies beyond the new width: the row ends right there
    write_reg(REG_OUT_WIDTH,    CFG_DATA_W'(3));
    send_walk(2, 0);
    wait_drained();
    // row 1 lies beyond the new height: the frame ends with this row
    write_reg(REG_OUT_HEIGHT,   CFG_DATA_W'(1));
    send_walk(4, 0);
    wait_drained();
  endtask

  // one column, oversize height: 300 rows take the source luma offset past
  // its field width
  task automatic test_tall_frame();
    write_reg(REG_SRC_ORIGIN_X, CFG_DATA_W'(4094));
    write_reg(REG_SRC_ORIGIN_Y, CFG_DATA_W'(4095));
    write_reg(REG_X_STEP,       STEP_RST);
    write_reg(REG_Y_STEP,       '1);
    write_reg(REG_OUT_WIDTH,    CFG_DATA_W'(1));
    write_reg(REG_OUT_HEIGHT,   '1);
    write_reg(REG_SRC_PITCH,    CFG_DATA_W'(16383));
    write_reg(REG_DST_PITCH,    CFG_DATA_W'(16383));
    send_request(1'b1);
    send_walk(299, 0);
    wait_drained();
  endtask

  // random setups, mostly plain raster walks with an occasional restart
  task automatic test_random_frames();
    repeat (16) begin
      randomize_setup();
      send_request(1'b1);
      send_walk($urandom_range(30, 60), 6);
      wait_drained();
    end
  endtask

  // receiver holds off long enough for the block to stall its input,
  // then the sender pauses until everything is back
  task automatic test_backpressure();
    randomize_setup();
    write_reg(REG_OUT_WIDTH,  CFG_DATA_W'(5));
    write_reg(REG_OUT_HEIGHT, CFG_DATA_W'(3));
    sink_hold = 1'b1;
    send_request(1'b1);
    send_walk(30, 5);
    wait_drained();
    send_walk(20, 5);
    wait_drained();
  endtask

  // closing stretch at full rate, no idling on either side
  task automatic test_full_rate();
    idle_en = 1'b0;
    repeat (2) begin
      randomize_setup();
      send_request(1'b1);
      send_walk(100, 3);
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : main
    // mirror starts at the register reset values
    cfg_ox     = '0;
    cfg_oy     = '0;
    cfg_xstep  = STEP_RST;
    cfg_ystep  = STEP_RST;
    cfg_w      = DIM_RST;
    cfg_h      = DIM_RST;
    cfg_spitch = '0;
    cfg_dpitch = '0;
    walk_col   = '0;
    walk_row   = '0;
    walk_xacc  = '0;
    walk_yacc  = '0;

    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_walk_extremes();
    test_size_limits();
    test_shrunk_size();
    test_tall_frame();
    test_random_frames();
    test_backpressure();
    test_full_rate();

    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
